@@ hdl/slrl_pkg.sv @@
`timescale 1ns / 1ps

package slrl_pkg;

   // operation codes of a request
   localparam logic [1:0] OP_PROJECT = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_FRAME   = 2'd2;

   // result status codes
   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_OUTSIDE = 3'd2;
   localparam logic [2:0] ST_READ    = 3'd3;
   localparam logic [2:0] ST_CLEARED = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_ROWS      = 2'd0;
   localparam logic [1:0] CSR_COLS      = 2'd1;
   localparam logic [1:0] CSR_COL_SCALE = 2'd2;
   localparam logic [1:0] CSR_ROW_SCALE = 2'd3;

   // datapath widths: 64-bit CORDIC words, Q16 angles
   localparam int DW  = 64;
   localparam int AW  = 20;
   localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [31:0]   GAIN_Q16    = 32'sd107922;
   localparam int PROD_FRAC = 28;

   localparam logic signed [17:0] EMPTY_CELL = -18'sd1;

   // arctangent ROM, round(atan(2^-i) * 2^16)
   function automatic logic signed [AW-1:0] atan_rom(input logic [4:0] i);
      logic signed [AW-1:0] r;
      begin
         case (i)
            5'd0:  r = 20'sd51472;
            5'd1:  r = 20'sd30386;
            5'd2:  r = 20'sd16055;
            5'd3:  r = 20'sd8150;
            5'd4:  r = 20'sd4091;
            5'd5:  r = 20'sd2047;
            5'd6:  r = 20'sd1024;
            5'd7:  r = 20'sd512;
            5'd8:  r = 20'sd256;
            5'd9:  r = 20'sd128;
            5'd10: r = 20'sd64;
            5'd11: r = 20'sd32;
            5'd12: r = 20'sd16;
            5'd13: r = 20'sd8;
            5'd14: r = 20'sd4;
            5'd15: r = 20'sd2;
            5'd16: r = 20'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // what the datapath tells the table controller when an item is done
   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [7:0]  row;
      logic [11:0] col;
      logic [19:0] num;
   } place_type;

endpackage

@@ hdl/slrl_cordic.sv @@
`timescale 1ns / 1ps

module slrl_cordic
   import slrl_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] x_init,
   input  logic signed [DW-1:0] y_init,
   output logic                 done,
   output logic signed [DW-1:0] x_out,
   output logic signed [AW-1:0] ang_out
);

   localparam int SW = $clog2(CORDIC_STEPS + 1);

   logic signed [DW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] a_ff, a_in;
   logic [SW-1:0]        step_ff, step_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic signed [DW-1:0] dx, dy;
   logic signed [AW-1:0] rom;

   // one micro-rotation per cycle, arithmetic shifts floor toward minus infinity
   always_comb begin
      dx      = y_ff >>> step_ff;
      dy      = x_ff >>> step_ff;
      rom     = atan_rom(5'(step_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      a_in    = a_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = x_init;
         y_in    = y_init;
         a_in    = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!y_ff[DW-1]) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            a_in = a_ff + rom;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            a_in = a_ff - rom;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      a_ff    <= a_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign x_out   = x_ff;
   assign ang_out = a_ff;

endmodule

@@ hdl/slrl_project.sv @@
`timescale 1ns / 1ps

module slrl_project
   import slrl_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int COORD_BITS   = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] point_z,
   input  logic [6:0]                   image_rows,
   input  logic [10:0]                  image_cols,
   input  logic signed [23:0]           col_scale,
   input  logic signed [23:0]           row_scale,
   output logic                         done,
   output logic                         outside,
   output logic [11:0]                  col_out,
   output logic [7:0]                   row_out
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_AZ   = 6'b000010,
      S_EL   = 6'b000100,
      S_MUL  = 6'b001000,
      S_RND  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic signed [DW-1:0] sx, sy, zg, cx_init, cy_init, c_x;
   logic signed [AW-1:0] c_ang, base_ff, base_in, az_ff, az_in;
   logic signed [COORD_BITS-1:0] z_ff;
   logic                 vert_in, c_start, c_done;
   logic signed [AW+23:0] cmul, rmul;
   logic signed [DW-1:0] cprod_ff, rprod_ff;
   logic signed [DW-1:0] cacc, racc;
   logic signed [DW-PROD_FRAC-1:0] cq, rq;
   logic signed [DW-PROD_FRAC-1:0] cq_ff, rq_ff;
   logic                 crup, rrup;
   logic signed [DW-1:0] ax, ay;

   // fold the point into the right half-plane before the azimuth pass
   always_comb begin
      sx = DW'(point_x) <<< 16;
      sy = DW'(point_y) <<< 16;
      ax = sx;
      ay = sy;
      base_in = '0;
      if (sx[DW-1]) begin
         if (!sy[DW-1]) begin
            ax = sy;  ay = -sx; base_in = HALF_PI_Q16;
         end else begin
            ax = -sy; ay = sx;  base_in = -HALF_PI_Q16;
         end
      end
      vert_in = (point_x == '0) && (point_y == '0);
   end

   assign zg = DW'(z_ff) * DW'(GAIN_Q16);

   always_comb begin
      c_start = 1'b0;
      cx_init = ax;
      cy_init = ay;
      state_in = state_ff;
      az_in = az_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            if (vert_in) begin
               c_start = 1'b1; cx_init = '0; cy_init = DW'(point_z) * DW'(GAIN_Q16);
               state_in = S_EL;
            end else begin
               c_start = 1'b1;
               state_in = S_AZ;
            end
         end
         S_AZ: if (c_done) begin
            az_in = base_ff + c_ang;
            c_start = 1'b1; cx_init = c_x; cy_init = zg;
            state_in = S_EL;
         end
         S_EL: if (c_done) state_in = S_MUL;
         S_MUL: state_in = S_RND;
         S_RND: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   slrl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (c_start),
      .x_init (cx_init),
      .y_init (cy_init),
      .done   (c_done),
      .x_out  (c_x),
      .ang_out(c_ang)
   );

   // scale times angle at its natural width
   assign cmul = col_scale * az_ff;
   assign rmul = row_scale * c_ang;

   // round half to even at the product scale
   always_comb begin
      cacc = cprod_ff + (DW'(image_cols >> 1) <<< PROD_FRAC);
      racc = rprod_ff + (DW'(image_rows >> 1) <<< PROD_FRAC);
      cq   = cacc[DW-1:PROD_FRAC];
      rq   = racc[DW-1:PROD_FRAC];
      crup = cacc[PROD_FRAC-1] &&
             ((cacc[PROD_FRAC-2:0] != '0) || cq[0]);
      rrup = racc[PROD_FRAC-1] &&
             ((racc[PROD_FRAC-2:0] != '0) || rq[0]);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         base_ff <= base_in;
         z_ff    <= point_z;
         if (vert_in) az_ff <= '0;
      end else begin
         az_ff <= az_in;
      end
      if (state_ff == S_EL && c_done) begin
         cprod_ff <= DW'(cmul);
         rprod_ff <= DW'(rmul);
      end
      if (state_ff == S_RND) begin
         cq_ff <= cq + (DW-PROD_FRAC)'(crup);
         rq_ff <= rq + (DW-PROD_FRAC)'(rrup);
      end
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign done    = (state_ff == S_DONE);
   assign outside = cq_ff[DW-PROD_FRAC-1] || rq_ff[DW-PROD_FRAC-1] ||
                    (cq_ff >= (DW-PROD_FRAC)'(image_cols)) ||
                    (rq_ff >= (DW-PROD_FRAC)'(image_rows));
   assign col_out = cq_ff[11:0];
   assign row_out = rq_ff[7:0];

endmodule

@@ hdl/spherical_lidar_range_lut_unit.sv @@
`timescale 1ns / 1ps
// channel | dir | payload
// req_    | in  | tuser: op; tdata: point_x, point_y, point_z, read_row, read_col
// rsp_    | out | tuser: status; tdata: cell_row, cell_col, cell_value
// csr_    | in  | wr_en, index, wdata (write only)
// A projection registers its result after the shared CORDIC unit has run azimuth then
// elevation (elevation only on the vertical axis); a read registers it in the cycle after
// acceptance, other requests and rejected projections at the accepting edge.
// After reset and after each new-frame request the table is swept back to empty,
// one cell a cycle over all MAX_ROWS*MAX_COLS cells; no request is taken meanwhile.
// The result register holds its item until rsp_tready; no request is taken while it is full.

module spherical_lidar_range_lut_unit
   import slrl_pkg::*;
#(
   parameter int MAX_ROWS     = 64,
   parameter int MAX_COLS     = 1024,
   parameter int MAX_POINTS   = 131072,
   parameter int CORDIC_STEPS = 16,
   parameter int COORD_BITS   = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   // point_x, point_y, point_z, read_row[6], read_col[10], zero fill
   input  logic [((3*COORD_BITS+16+7)/8)*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0]
   output logic [2:0]   rsp_tuser,
   // cell_row[5:0], cell_col[15:6], cell_value[33:16], zero fill
   output logic [39:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_wdata
);

   localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int TAB   = $clog2(DEPTH + 1);
   localparam int NB    = $clog2(MAX_POINTS + 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_PROJ  = 6'b001000,
      S_RESP  = 6'b010000,
      S_RDOUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]         rows_ff;
   logic [10:0]        cols_ff;
   logic signed [23:0] cscale_ff, rscale_ff;

   logic [17:0] mem [DEPTH];
   logic [17:0] rd_ff;
   logic [TAB-1:0] clr_ff;
   logic [NB-1:0]  cnt_ff;
   logic [2:0]  st_ff;
   logic [5:0]  row_ff;
   logic [9:0]  col_ff;
   logic [17:0] val_ff;
   logic        beyond_ff;
   logic        out_valid_ff;

   logic [1:0] op;
   logic signed [COORD_BITS-1:0] px, py, pz;
   logic [5:0] rrow;
   logic [9:0] rcol;
   logic       p_start, p_done, p_out;
   logic [11:0] p_col;
   logic [7:0]  p_row;
   logic [NB-1:0] num_ff;

   assign op   = req_tuser;
   assign px   = req_tdata[0 +: COORD_BITS];
   assign py   = req_tdata[COORD_BITS +: COORD_BITS];
   assign pz   = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign rrow = req_tdata[3*COORD_BITS +: 6];
   assign rcol = req_tdata[6+3*COORD_BITS +: 10];

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   wire accept = req_tvalid && req_tready;

   // configuration writes, saturated dimensions
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 7'((64 < MAX_ROWS) ? 64 : MAX_ROWS);
         cols_ff   <= 11'((1024 < MAX_COLS) ? 1024 : MAX_COLS);
         cscale_ff <= -24'sd667546;
         rscale_ff <= -24'sd500654;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= (32'(csr_wdata[6:0]) > MAX_ROWS) ?
                                 7'(MAX_ROWS) : csr_wdata[6:0];
            CSR_COLS: cols_ff <= (32'(csr_wdata[10:0]) > MAX_COLS) ?
                                 11'(MAX_COLS) : csr_wdata[10:0];
            CSR_COL_SCALE: cscale_ff <= csr_wdata;
            CSR_ROW_SCALE: rscale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign p_start = accept && (op == OP_PROJECT) && !(32'(cnt_ff) >= MAX_POINTS) &&
                    !((px == '0) && (py == '0) && (pz == '0));

   slrl_project #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_BITS(COORD_BITS)) u_project (
      .clock     (clock),
      .reset     (reset),
      .start     (p_start),
      .point_x   (px),
      .point_y   (py),
      .point_z   (pz),
      .image_rows(rows_ff),
      .image_cols(cols_ff),
      .col_scale (cscale_ff),
      .row_scale (rscale_ff),
      .done      (p_done),
      .outside   (p_out),
      .col_out   (p_col),
      .row_out   (p_row)
   );

   // table RAM: one write, one registered read
   wire wr_clear = (state_ff == S_CLEAR);
   wire wr_point = (state_ff == S_PROJ) && p_done && !p_out;
   wire [TAB-1:0] rd_addr = TAB'(rrow) * TAB'(MAX_COLS) + TAB'(rcol);
   wire [TAB-1:0] wr_addr = wr_clear ? clr_ff :
                            TAB'(p_row) * TAB'(MAX_COLS) + TAB'(p_col);

   always_ff @(posedge clock) begin
      if (wr_clear || wr_point)
         mem[wr_addr[$clog2(DEPTH)-1:0]] <= wr_clear ? EMPTY_CELL : 18'(num_ff);
      rd_ff <= mem[rd_addr[$clog2(DEPTH)-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (32'(clr_ff) == DEPTH - 1) state_in = S_IDLE;
         S_IDLE:  if (accept) begin
            if (op == OP_FRAME)      state_in = S_CLEAR;
            else if (op == OP_READ)  state_in = S_READ;
            else if (p_start)        state_in = S_PROJ;
         end
         S_READ:  state_in = S_RDOUT;
         S_RDOUT: state_in = S_IDLE;
         S_PROJ:  if (p_done) state_in = S_IDLE;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         else                      clr_ff <= '0;
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         if (accept) begin
            case (op)
               OP_FRAME: begin
                  cnt_ff <= '0; out_valid_ff <= 1'b1;
                  st_ff <= ST_CLEARED; row_ff <= '0; col_ff <= '0; val_ff <= EMPTY_CELL;
               end
               OP_READ: begin
                  row_ff <= rrow; col_ff <= rcol; st_ff <= ST_READ;
                  beyond_ff <= (32'(rrow) >= MAX_ROWS) || (32'(rcol) >= MAX_COLS);
               end
               OP_PROJECT: begin
                  if (32'(cnt_ff) >= MAX_POINTS) begin
                     out_valid_ff <= 1'b1; st_ff <= ST_FULL;
                     row_ff <= '0; col_ff <= '0; val_ff <= EMPTY_CELL;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                     num_ff <= cnt_ff;
                     if (!p_start) begin
                        out_valid_ff <= 1'b1; st_ff <= ST_ZERO;
                        row_ff <= '0; col_ff <= '0; val_ff <= 18'(cnt_ff);
                     end
                  end
               end
               default: ;
            endcase
         end
         // take the read data while it still belongs to the accepted address
         if (state_ff == S_READ) begin
            out_valid_ff <= 1'b1;
            val_ff <= beyond_ff ? EMPTY_CELL : rd_ff;
         end
         if (state_ff == S_PROJ && p_done) begin
            out_valid_ff <= 1'b1;
            val_ff <= 18'(num_ff);
            st_ff  <= p_out ? ST_OUTSIDE : ST_STORED;
            row_ff <= p_out ? 6'd0 : 6'(p_row);
            col_ff <= p_out ? 10'd0 : 10'(p_col);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = st_ff;
   assign rsp_tdata  = {6'b000000, val_ff, col_ff, row_ff};

endmodule
